>>> rtl/glq_pkg.sv
// ----------------------------------------------------------------------------
// Gray level quantizer package
// Shared item types, command codes, status codes and controller handshake.
// ----------------------------------------------------------------------------
package glq_pkg;

  // Command carried by an input item.
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_MAP     = 1'b1;

  // Status codes carried by a result item.
  localparam logic [1:0] ST_MAPPED = 2'd0;
  localparam logic [1:0] ST_WITHIN = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_ABOVE  = 2'd3;

  // Register values after reset, and the full-scale pixel.
  localparam logic [7:0] LEVELS_RST = 8'd2;
  localparam logic [7:0] MIN_RST    = 8'd255;
  localparam logic [7:0] MAX_RST    = 8'd0;
  localparam logic [7:0] PIX_MAX    = 8'd255;

  // Bounds are held in half units and capped at 255.0.
  localparam logic [10:0] BOUND_CAP = 11'd510;

  // Restoring divider: one quotient bit per step over a 9-bit dividend.
  localparam int unsigned DIV_W     = 9;
  localparam int unsigned DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level_value;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WDIV,
    S_WSTORE,
    S_QDIV,
    S_CALC,
    S_EMIT
  } glq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_trivial;
    logic start_wdiv;
    logic start_qdiv;
    logic div_step;
    logic store_width;
    logic calc;
    logic emit;
  } glq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_map;
    logic trivial;
    logic width_ok;
    logic div_last;
    logic out_free;
  } glq_sts_t;

endpackage

>>> rtl/gray_level_quantizer_unit.sv
// ----------------------------------------------------------------------------
// Gray level quantizer unit
// Uniform quantization of 8-bit gray pixels in two passes: measure, then map.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    glq_pkg::in_item_t (cmd, pixel, first)
//   out_     output     out_valid/out_ready  glq_pkg::out_item_t (level_value, status)
//   cfg_     input      cfg_valid/cfg_ready  levels, 8 bits
//
// A measure transfer updates the minimum and maximum and yields no result.
// A map transfer that needs no division (narrow range or zero levels) goes from the
// decision to the result stage; any other first runs the 9-step restoring divider.
// After a measure transfer or a levels write the interval width is recomputed on
// the same divider for the next mapped pixel, before that pixel's own division.
// Reset is synchronous and active low; it restores levels 2, minimum 255, maximum 0.
// A result waiting in the output register does not block the next input transfer;
// only the finishing step of a map item waits for the output register to drain.
//
module gray_level_quantizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  glq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output glq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  glq_pkg::glq_cmd_t cmd;
  glq_pkg::glq_sts_t sts;

  // A levels write is taken at any time: the user, not the block, keeps writes to idle.
  assign cfg_ready = 1'b1;

  // The controller steps through the checks, the division and the result stage.
  glq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the data registers, the divider and the output register.
  glq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/glq_ctrl.sv
// ----------------------------------------------------------------------------
// Gray level quantizer controller
// Accepts items; steps a map item through checks, divider and result stage.
// ----------------------------------------------------------------------------
module glq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  glq_pkg::glq_sts_t sts,
  output glq_pkg::glq_cmd_t cmd
);

  glq_pkg::glq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      glq_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.in_is_map) begin
          state_nxt = glq_pkg::S_DECIDE;
        end
      end
      glq_pkg::S_DECIDE: begin
        priority if (sts.trivial) begin
          cmd.load_trivial = 1'b1;
          state_nxt        = glq_pkg::S_EMIT;
        end else if (sts.width_ok) begin
          cmd.start_qdiv = 1'b1;
          state_nxt      = glq_pkg::S_QDIV;
        end else begin
          cmd.start_wdiv = 1'b1;
          state_nxt      = glq_pkg::S_WDIV;
        end
      end
      glq_pkg::S_WDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = glq_pkg::S_WSTORE;
        end
      end
      glq_pkg::S_WSTORE: begin
        cmd.store_width = 1'b1;
        state_nxt       = glq_pkg::S_DECIDE;
      end
      glq_pkg::S_QDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = glq_pkg::S_CALC;
        end
      end
      glq_pkg::S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = glq_pkg::S_EMIT;
      end
      glq_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = glq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = glq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/glq_dp.sv
// ----------------------------------------------------------------------------
// Gray level quantizer datapath
// Min/max tracking, level register, cached width, restoring divider, result
// arithmetic and the output register.
// ----------------------------------------------------------------------------
module glq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  glq_pkg::in_item_t  in_data,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output glq_pkg::out_item_t out_data,
  input  glq_pkg::glq_cmd_t  cmd,
  output glq_pkg::glq_sts_t  sts
);

  logic [7:0] min_r, min_nxt;
  logic [7:0] max_r, max_nxt;
  logic [7:0] levels_r, levels_nxt;
  logic       width_ok_r, width_ok_nxt;
  logic [8:0] width_r, width_nxt;
  logic [7:0] pix_r, pix_nxt;

  logic [glq_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [glq_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [glq_pkg::DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [glq_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [7:0] res_val_r, res_val_nxt;
  logic [1:0] res_st_r, res_st_nxt;

  logic                out_valid_r, out_valid_nxt;
  glq_pkg::out_item_t  out_data_r, out_data_nxt;

  logic [7:0]  diff;
  logic        narrow;
  logic        zero_lv;
  logic [8:0]  span;
  logic [7:0]  offset;
  logic [9:0]  trial;
  logic [7:0]  qw;
  logic [10:0] lo_b;
  logic [10:0] hi_raw;
  logic [10:0] hi_b;
  logic [10:0] mid_sum;
  logic        above;
  logic        out_free;

  // Checks on the measured range.
  assign diff    = max_r - min_r;
  assign narrow  = (max_r < min_r) || (diff < levels_r);
  assign zero_lv = (levels_r == 8'd0);
  assign span    = {1'b0, diff} + 9'd1;
  assign offset  = (pix_r >= min_r) ? (pix_r - min_r) : 8'd0;

  // One restoring step.
  assign trial = {rem_r, quo_r[glq_pkg::DIV_W-1]} - {1'b0, dsr_r};

  // The remainder of offset / width gives quotient times width without a multiplier.
  assign qw      = offset - rem_r[7:0];
  assign lo_b    = 11'({min_r, 1'b0}) + 11'({qw, 1'b0});
  assign hi_raw  = lo_b + 11'({width_r, 1'b0}) - 11'd1;
  assign hi_b    = (hi_raw > glq_pkg::BOUND_CAP) ? glq_pkg::BOUND_CAP : hi_raw;
  assign mid_sum = lo_b + hi_b - 11'd1;
  assign above   = (pix_r == glq_pkg::PIX_MAX) || (qw > diff);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    min_nxt      = min_r;
    max_nxt      = max_r;
    levels_nxt   = levels_r;
    width_ok_nxt = width_ok_r;
    width_nxt    = width_r;
    pix_nxt      = pix_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    dsr_nxt      = dsr_r;
    cnt_nxt      = cnt_r;
    res_val_nxt  = res_val_r;
    res_st_nxt   = res_st_r;

    if (cfg_valid) begin
      levels_nxt   = cfg_data;
      width_ok_nxt = 1'b0;
    end

    if (cmd.accept) begin
      pix_nxt = in_data.pixel;
      if (in_data.cmd == glq_pkg::CMD_MEASURE) begin
        width_ok_nxt = 1'b0;
        if (in_data.first) begin
          min_nxt = in_data.pixel;
          max_nxt = in_data.pixel;
        end else begin
          if (in_data.pixel < min_r) begin
            min_nxt = in_data.pixel;
          end
          if (in_data.pixel > max_r) begin
            max_nxt = in_data.pixel;
          end
        end
      end
    end

    if (cmd.load_trivial) begin
      res_val_nxt = pix_r;
      res_st_nxt  = narrow ? glq_pkg::ST_WITHIN : glq_pkg::ST_ZERO;
    end

    if (cmd.start_wdiv) begin
      quo_nxt = span;
      rem_nxt = '0;
      dsr_nxt = {1'b0, levels_r};
      cnt_nxt = '0;
    end

    if (cmd.start_qdiv) begin
      quo_nxt = {1'b0, offset};
      rem_nxt = '0;
      dsr_nxt = width_r;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      cnt_nxt = cnt_r + 1'b1;
      if (!trial[glq_pkg::DIV_W]) begin
        rem_nxt = trial[glq_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[glq_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[glq_pkg::DIV_W-2:0], quo_r[glq_pkg::DIV_W-1]};
        quo_nxt = {quo_r[glq_pkg::DIV_W-2:0], 1'b0};
      end
    end

    if (cmd.store_width) begin
      width_nxt    = quo_r;
      width_ok_nxt = 1'b1;
    end

    if (cmd.calc) begin
      if (above) begin
        res_val_nxt = pix_r;
        res_st_nxt  = glq_pkg::ST_ABOVE;
      end else begin
        res_val_nxt = mid_sum[9:2];
        res_st_nxt  = glq_pkg::ST_MAPPED;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.level_value = res_val_r;
      out_data_nxt.status      = res_st_r;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= glq_pkg::MIN_RST;
      max_r       <= glq_pkg::MAX_RST;
      levels_r    <= glq_pkg::LEVELS_RST;
      width_ok_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      levels_r    <= levels_nxt;
      width_ok_r  <= width_ok_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    width_r    <= width_nxt;
    pix_r      <= pix_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.in_is_map = (in_data.cmd == glq_pkg::CMD_MAP);
  assign sts.trivial   = narrow || zero_lv;
  assign sts.width_ok  = width_ok_r;
  assign sts.div_last  = (cnt_r == glq_pkg::DIV_LAST);
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/glq_checker.sv
// ----------------------------------------------------------------------------
// Gray level quantizer checker
// Port-level assertions on transfers, bound to the top level.
// ----------------------------------------------------------------------------
module glq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input glq_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input glq_pkg::out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A map transfer makes the block busy in the following cycle.
  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == glq_pkg::CMD_MAP) |=> !in_ready)
    else $error("input taken straight after a map transfer");

  // After a measure transfer the block is ready again in the following cycle.
  a_measure_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == glq_pkg::CMD_MEASURE) |=> in_ready)
    else $error("block busy after a measure transfer");

  // A new result only appears at the end of a busy period.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a map item in flight");

  // A midpoint of two capped bounds never reaches full scale.
  a_mapped_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == glq_pkg::ST_MAPPED) |->
      (out_data.level_value != glq_pkg::PIX_MAX))
    else $error("mapped level at full scale");

endmodule

bind gray_level_quantizer_unit glq_checker u_glq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/gray_level_quantizer_checker.sv
// ----------------------------------------------------------------------------
// Gray level quantizer checker
// Watches the three channels of the quantizer, keeps its own copy of the
// minimum, maximum and level count, predicts the result of every map transfer
// and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module gray_level_quantizer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  glq_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  glq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 mismatch_count,
  output int                 results_due
);

  logic [7:0]         level_count;
  logic [7:0]         lo_seen;
  logic [7:0]         hi_seen;
  glq_pkg::out_item_t expected_levels[$];
  glq_pkg::out_item_t oldest;

  // Interval bound k in half units, capped at 255.0.
  function automatic int bound_half(int lo, int k, int width);
    int b;
    b = 2 * lo - 1 + 2 * k * width;
    return (b > int'(glq_pkg::BOUND_CAP)) ? int'(glq_pkg::BOUND_CAP) : b;
  endfunction

  function automatic glq_pkg::out_item_t quantize_pixel(logic [7:0] pixel);
    int                 lo;
    int                 hi;
    int                 span;
    int                 width;
    int                 limit;
    int                 k;
    int                 cur;
    bit                 found;
    glq_pkg::out_item_t r;
    lo            = int'(lo_seen);
    hi            = int'(hi_seen);
    r.level_value = pixel;
    r.status      = glq_pkg::ST_MAPPED;
    span          = hi - lo + 1;
    if (span <= int'(level_count)) begin
      r.status = glq_pkg::ST_WITHIN;
    end else if (level_count == 8'd0) begin
      r.status = glq_pkg::ST_ZERO;
    end else begin
      width = span / int'(level_count);
      limit = 2 * (hi + width);
      if (int'(pixel) < lo) begin
        r.level_value = 8'((bound_half(lo, 1, width) + bound_half(lo, 0, width)) / 4);
      end else begin
        found = 1'b0;
        for (k = 1; !found && (2 * lo - 1 + 2 * k * width < limit); k++) begin
          cur = bound_half(lo, k, width);
          if (2 * int'(pixel) < cur) begin
            r.level_value = 8'((cur + bound_half(lo, k - 1, width)) / 4);
            found         = 1'b1;
          end
        end
        if (!found) r.status = glq_pkg::ST_ABOVE;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      level_count = glq_pkg::LEVELS_RST;
      lo_seen     = glq_pkg::MIN_RST;
      hi_seen     = glq_pkg::MAX_RST;
      expected_levels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected result, got level %0d status %0d",
                   $time, out_data.level_value, out_data.status);
          mismatch_count++;
        end else begin
          oldest = expected_levels.pop_front();
          if (out_data.level_value !== oldest.level_value ||
              out_data.status !== oldest.status) begin
            $display("%0t: expected level %0d status %0d, got level %0d status %0d",
                     $time, oldest.level_value, oldest.status,
                     out_data.level_value, out_data.status);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) level_count = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.cmd == glq_pkg::CMD_MEASURE) begin
          if (in_data.first) begin
            lo_seen = in_data.pixel;
            hi_seen = in_data.pixel;
          end else begin
            if (in_data.pixel < lo_seen) lo_seen = in_data.pixel;
            if (in_data.pixel > hi_seen) hi_seen = in_data.pixel;
          end
        end else begin
          expected_levels = {expected_levels, quantize_pixel(in_data.pixel)};
        end
      end
    end
    results_due = expected_levels.size();
  end

endmodule

>>> tb/gray_level_quantizer_unit_test.sv
// ----------------------------------------------------------------------------
// Gray level quantizer unit test
// Drives measure and map transfers into the quantizer with random gaps and
// random back-pressure, steps the level count through its extremes between
// phases, and lets the checker compare every result with its prediction.
// ----------------------------------------------------------------------------
module gray_level_quantizer_unit_test;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1700;
  // Covers a mapped pixel after a range change, width division included, plus a margin.
  localparam int SETTLE       = 40;
  // The receiver holds off for this many cycles now and then, long enough for
  // the quantizer to fill its output register and stop taking input.
  localparam int LONG_HOLD    = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  glq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  glq_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;

  int mismatch_count;
  int results_due;
  int cycle_count = 0;
  int random_sent = 0;

  gray_level_quantizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  gray_level_quantizer_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog: a run that hangs, or leaves a result outstanding, ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Most gaps are zero or a few cycles; now and then a long one, so that
  // idle cycles land on every phase of the divider.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offers one item and returns at the falling edge after its transfer. The
  // valid stays high when the next item follows with no gap, so that it is
  // never lowered and raised within the same time step.
  task automatic offer_item(logic cmd, logic [7:0] pixel, logic first);
    int                gap;
    glq_pkg::in_item_t item;
    gap        = pick_gap();
    item.cmd   = cmd;
    item.pixel = pixel;
    item.first = first;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // The level count is only changed while the quantizer is idle: every
  // predicted result must have come back, and the extra settling cycles
  // are waited on top of that.
  task automatic write_levels(logic [7:0] value);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: bursts of readiness broken by stalls. Occasional long bursts
  // give stretches with no back-pressure at all, and a few very long holds
  // force the quantizer to stop accepting input.
  initial begin
    int run;
    int stall;
    int burst;
    burst = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      burst++;
      run   = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 80) : $urandom_range(6, 1);
      stall = pick_gap() + 1;
      if (burst == 30 || burst % 250 == 0) stall = LONG_HOLD;
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
  end

  initial begin
    int         roll;
    int         lo;
    int         hi;
    int         n_measure;
    int         n_map;
    logic [7:0] level_pick;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. With nothing measured yet the range is empty, so a map
    // transfer passes the pixel through; the first flag means nothing on a map.
    offer_item(glq_pkg::CMD_MAP, 8'd77, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd0, 1'b1);
    // Full range with the reset level count of two.
    offer_item(glq_pkg::CMD_MEASURE, 8'd0, 1'b1);
    offer_item(glq_pkg::CMD_MEASURE, 8'd255, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd0, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd127, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd128, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd255, 1'b0);
    // Zero levels is refused and the pixel passes through.
    write_levels(8'd0);
    offer_item(glq_pkg::CMD_MAP, 8'd10, 1'b0);
    // One level: one wide interval, and the top pixel sits on the last bound.
    write_levels(8'd1);
    offer_item(glq_pkg::CMD_MAP, 8'd254, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd255, 1'b0);
    // Most levels: unit width over the full range.
    write_levels(8'd255);
    offer_item(glq_pkg::CMD_MAP, 8'd200, 1'b0);
    // A narrower range than the level count is left as it is.
    offer_item(glq_pkg::CMD_MEASURE, 8'd100, 1'b1);
    offer_item(glq_pkg::CMD_MEASURE, 8'd200, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd150, 1'b0);
    // Four levels over 100..200: below the minimum, inside, and past the
    // last bound.
    write_levels(8'd4);
    offer_item(glq_pkg::CMD_MAP, 8'd50, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd199, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd200, 1'b0);
    offer_item(glq_pkg::CMD_MAP, 8'd225, 1'b0);
    // A single measured value gives a span of one.
    offer_item(glq_pkg::CMD_MEASURE, 8'd255, 1'b1);
    offer_item(glq_pkg::CMD_MAP, 8'd255, 1'b0);

    // Random part: per level setting a few measure-then-map sequences, with
    // some noise thrown in (no restart, stray measures, pixels off range).
    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(9, 0);
      case (roll)
        0:       level_pick = 8'd0;
        1:       level_pick = 8'd1;
        2:       level_pick = 8'd255;
        3, 4, 5, 6: level_pick = 8'($urandom_range(8, 2));
        default: level_pick = 8'($urandom_range(255, 0));
      endcase
      write_levels(level_pick);
      repeat ($urandom_range(6, 3)) begin
        if ($urandom_range(3, 0) == 0) begin
          lo = 0;
          hi = 255;
        end else begin
          lo = $urandom_range(255, 0);
          hi = $urandom_range(255, lo);
        end
        if ($urandom_range(9, 0) != 0) begin
          offer_item(glq_pkg::CMD_MEASURE, 8'($urandom_range(hi, lo)), 1'b1);
          random_sent++;
        end
        n_measure = $urandom_range(12, 1);
        repeat (n_measure) begin
          if ($urandom_range(9, 0) == 0)
            offer_item(glq_pkg::CMD_MEASURE, 8'($urandom_range(255, 0)),
                       1'($urandom_range(1, 0)));
          else
            offer_item(glq_pkg::CMD_MEASURE, 8'($urandom_range(hi, lo)), 1'b0);
        end
        n_map = $urandom_range(24, 1);
        repeat (n_map) begin
          if ($urandom_range(4, 0) == 0)
            offer_item(glq_pkg::CMD_MAP, 8'($urandom_range(255, 0)),
                       1'($urandom_range(1, 0)));
          else
            offer_item(glq_pkg::CMD_MAP, 8'($urandom_range(hi, lo)),
                       1'($urandom_range(1, 0)));
        end
        random_sent += n_measure + n_map;
      end
    end

    // Drain: wait for every predicted result, then a little longer to catch
    // any stray extra transfer.
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
